/* rtl/pqe_pkg.sv */
// Shared types, codes and default sizes for the process queue engine.
// Depends on nothing; the interfaces, the top and the queue table import it.
package pqe_pkg;

    localparam int DEF_NUM_SLOTS  = 64;
    localparam int DEF_NUM_QUEUES = 4;

    localparam int OP_W   = 2;
    localparam int QSEL_W = 2;
    localparam int PID_W  = 6;
    localparam int STAT_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_PEEK   = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_EMPTY     = 3'd1,
        STAT_DUPLICATE = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_REFUSED   = 3'd4,
        STAT_IDLE_RET  = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

    // Update strobes for the queue end table.
    typedef struct packed {
        logic set_ne;
        logic clr_ne;
        logic head_we;
        logic tail_we;
    } t_qupd;

endpackage

/* rtl/pqe_if.sv */
// Request and response channel interfaces of the process queue engine.
// Depends on pqe_pkg for the payload widths.
interface pqe_req_if import pqe_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [QSEL_W-1:0] queue_select;
    logic [PID_W-1:0]  process_id;

    modport source (output valid, operation, queue_select, process_id, input ready);
    modport sink   (input valid, operation, queue_select, process_id, output ready);
endinterface

interface pqe_rsp_if import pqe_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [PID_W-1:0]  result_id;
    logic              now_empty;

    modport source (output valid, status, result_id, now_empty, input ready);
    modport sink   (input valid, status, result_id, now_empty, output ready);
endinterface

/* rtl/process_queue_engine_top.sv */
// Process queue engine: FIFO queues of process slots as doubly linked lists.
// A request starts its link memory reads when it is accepted and is acted on in the
// execute state; its result beat then goes to the output register, and the execute
// state waits while the previous result beat is still waiting in the output register.
// A new request is accepted only once the previous one has left its execute state,
// in which the neighbours' links are written back. Reset: synchronous, active low;
// afterwards a clearing pass over every slot zeroes the owner memory, and no request is accepted until it completes.
module process_queue_engine_top import pqe_pkg::*; #(
    parameter int NUM_SLOTS  = DEF_NUM_SLOTS,
    parameter int NUM_QUEUES = DEF_NUM_QUEUES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    pqe_req_if.sink          i_req,
    pqe_rsp_if.source        o_rsp,
    input  logic             i_cfg_we,
    input  logic [PID_W-1:0] i_cfg_wdata
);
    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    // Owner code: zero for a free slot, queue number plus one otherwise.
    localparam int OW = $clog2(NUM_QUEUES + 1);

    // Control state: the clearing pass, waiting for a request, and the
    // execute cycle in which the memory read data is acted upon.
    t_state r_state, n_state;
    logic [SW-1:0] r_clr_cnt, n_clr_cnt;

    // The idle process id, written through the configuration port.
    logic [PID_W-1:0] r_idle;

    // The request held for its execute cycle.
    logic [OP_W-1:0]   r_op;
    logic [QSEL_W-1:0] r_qsel;
    logic [PID_W-1:0]  r_pid;
    logic [SW-1:0]     r_addr;

    // Output register, which frees the request side from the response side.
    logic              r_rsp_valid;
    logic [STAT_W-1:0] r_status;
    logic [PID_W-1:0]  r_rid;
    logic              r_empty;

    logic          w_accept;
    logic          w_go;
    logic          w_in_qok;
    logic [QW-1:0] w_in_qi;
    logic [SW-1:0] w_in_addr;
    logic          w_qok;
    logic          w_idok;
    logic [QW-1:0] w_qi;
    logic [QW-1:0] w_qt_idx;
    logic [SW-1:0] w_head;
    logic [SW-1:0] w_tail;
    logic          w_ne;
    logic [SW-1:0] w_raddr;
    logic [SW-1:0] w_rd_next;
    logic [SW-1:0] w_rd_prev;
    logic [OW-1:0] w_rd_owner;
    logic [OW-1:0] w_own_code;
    logic          w_own_match;
    logic          w_is_head;
    logic          w_is_tail;

    t_status          w_status;
    logic [PID_W-1:0] w_rid;
    logic             w_ne_after;
    logic             w_push_ok;
    logic             w_unlink;

    logic          w_own_we;
    logic [SW-1:0] w_own_waddr;
    logic [OW-1:0] w_own_wdata;
    logic          w_nxt_we;
    logic [SW-1:0] w_nxt_waddr;
    logic [SW-1:0] w_nxt_wdata;
    logic          w_prv_we;
    logic [SW-1:0] w_prv_waddr;
    logic [SW-1:0] w_prv_wdata;
    t_qupd         w_qupd;
    logic [SW-1:0] w_qt_head;
    logic [SW-1:0] w_qt_tail;

    // Requests are taken only between operations, so a read never meets
    // a write-back of the previous operation on the same entry.
    assign i_req.ready = (r_state == ST_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;

    // The execute cycle completes once the output register is free.
    assign w_go = (r_state == ST_EXEC) && (!r_rsp_valid || o_rsp.ready);

    // Decode of the incoming request, used to start the memory reads.
    assign w_in_qok = (32'(i_req.queue_select) < NUM_QUEUES);
    assign w_in_qi  = w_in_qok ? QW'(i_req.queue_select) : '0;

    // Decode of the held request. A queue number beyond the table falls back
    // to queue zero for the lookups, whose results are then ignored.
    assign w_qok  = (32'(r_qsel) < NUM_QUEUES);
    assign w_idok = (32'(r_pid) < NUM_SLOTS);
    assign w_qi   = w_qok ? QW'(r_qsel) : '0;

    assign w_qt_idx = (r_state == ST_EXEC) ? w_qi : w_in_qi;

    pqe_qtable #(
        .NUM_SLOTS  (NUM_SLOTS),
        .NUM_QUEUES (NUM_QUEUES)
    ) u_qtable (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_idx   (w_qt_idx),
        .o_head     (w_head),
        .o_tail     (w_tail),
        .o_nonempty (w_ne),
        .i_wr_idx   (w_qi),
        .i_upd      (w_qupd),
        .i_head     (w_qt_head),
        .i_tail     (w_qt_tail)
    );

    // A pop works on the head slot of its queue; push and remove on the
    // given id. The address is held through the execute cycle so that a
    // stalled operation keeps reading the same entry.
    assign w_in_addr = (i_req.operation == OP_POP) ? w_head : SW'(i_req.process_id);
    assign w_raddr   = (r_state == ST_EXEC) ? r_addr : w_in_addr;

    pqe_ram #(.WIDTH(SW), .DEPTH(NUM_SLOTS)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (w_nxt_we),
        .i_waddr (w_nxt_waddr),
        .i_wdata (w_nxt_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_next)
    );

    pqe_ram #(.WIDTH(SW), .DEPTH(NUM_SLOTS)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (w_prv_we),
        .i_waddr (w_prv_waddr),
        .i_wdata (w_prv_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_prev)
    );

    pqe_ram #(.WIDTH(OW), .DEPTH(NUM_SLOTS)) u_owner_ram (
        .i_clk   (i_clk),
        .i_we    (w_own_we),
        .i_waddr (w_own_waddr),
        .i_wdata (w_own_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_owner)
    );

    assign w_own_code  = OW'(32'(r_qsel) + 1);
    assign w_own_match = (w_rd_owner == w_own_code);
    assign w_is_head   = (w_head == r_addr);
    assign w_is_tail   = (w_tail == r_addr);

    // Next state, result and the read-modify-write of the link memories.
    always_comb begin
        n_state     = r_state;
        n_clr_cnt   = r_clr_cnt;
        w_status    = STAT_OK;
        w_rid       = r_pid;
        w_ne_after  = w_ne;
        w_push_ok   = 1'b0;
        w_unlink    = 1'b0;
        w_own_we    = 1'b0;
        w_own_waddr = r_addr;
        w_own_wdata = '0;
        w_nxt_we    = 1'b0;
        w_nxt_waddr = w_tail;
        w_nxt_wdata = r_addr;
        w_prv_we    = 1'b0;
        w_prv_waddr = r_addr;
        w_prv_wdata = w_tail;
        w_qupd      = '0;
        w_qt_head   = r_addr;
        w_qt_tail   = r_addr;

        unique case (r_state)
            ST_CLEAR: begin
                // Sweep the owner memory so that every slot reads as free.
                w_own_we    = 1'b1;
                w_own_waddr = r_clr_cnt;
                if (r_clr_cnt == SW'(NUM_SLOTS - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr_cnt = r_clr_cnt + 1'b1;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (t_op'(r_op))
                    OP_PUSH: begin
                        // The idle id is refused by the ready queue before
                        // the duplicate check is made.
                        if (!w_qok || !w_idok) begin
                            w_status = STAT_REFUSED;
                        end else if (r_qsel == '0 && r_pid == r_idle) begin
                            w_status = STAT_REFUSED;
                        end else if (w_own_match) begin
                            w_status = STAT_DUPLICATE;
                        end else if (w_rd_owner != '0) begin
                            w_status = STAT_REFUSED;
                        end else begin
                            w_push_ok  = 1'b1;
                            w_ne_after = 1'b1;
                        end
                    end
                    OP_POP: begin
                        if (!w_qok || !w_ne) begin
                            w_status = STAT_EMPTY;
                        end else begin
                            w_rid    = PID_W'(w_head);
                            w_unlink = 1'b1;
                        end
                    end
                    OP_REMOVE: begin
                        if (!w_qok || !w_idok || !w_own_match) begin
                            w_status = STAT_NOT_FOUND;
                        end else begin
                            w_unlink = 1'b1;
                        end
                    end
                    OP_PEEK: begin
                        if (w_qok && w_ne) begin
                            w_rid = PID_W'(w_head);
                        end else if (r_qsel == '0) begin
                            w_status = STAT_IDLE_RET;
                            w_rid    = r_idle;
                        end else begin
                            w_status = STAT_EMPTY;
                        end
                    end
                endcase

                if (w_unlink && w_is_head && w_is_tail) begin
                    w_ne_after = 1'b0;
                end

                if (w_go) begin
                    n_state = ST_IDLE;
                    if (w_push_ok) begin
                        w_own_we       = 1'b1;
                        w_own_wdata    = w_own_code;
                        w_qupd.tail_we = 1'b1;
                        if (w_ne) begin
                            // Link the old tail forwards and the new slot back.
                            w_nxt_we = 1'b1;
                            w_prv_we = 1'b1;
                        end else begin
                            w_qupd.head_we = 1'b1;
                            w_qupd.set_ne  = 1'b1;
                        end
                    end
                    if (w_unlink) begin
                        w_own_we = 1'b1;
                        if (w_is_head && w_is_tail) begin
                            w_qupd.clr_ne = 1'b1;
                        end else if (w_is_head) begin
                            w_qupd.head_we = 1'b1;
                            w_qt_head      = w_rd_next;
                        end else if (w_is_tail) begin
                            w_qupd.tail_we = 1'b1;
                            w_qt_tail      = w_rd_prev;
                        end else begin
                            // Slot in the middle: join its two neighbours.
                            w_nxt_we    = 1'b1;
                            w_nxt_waddr = w_rd_prev;
                            w_nxt_wdata = w_rd_next;
                            w_prv_we    = 1'b1;
                            w_prv_waddr = w_rd_next;
                            w_prv_wdata = w_rd_prev;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_clr_cnt <= n_clr_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle <= '0;
        end else if (i_cfg_we) begin
            r_idle <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= i_req.operation;
            r_qsel <= i_req.queue_select;
            r_pid  <= i_req.process_id;
            r_addr <= w_in_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (w_go) begin
            r_rsp_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_status <= w_status;
            r_rid    <= w_rid;
            r_empty  <= !(w_qok && w_ne_after);
        end
    end

    assign o_rsp.valid     = r_rsp_valid;
    assign o_rsp.status    = r_status;
    assign o_rsp.result_id = r_rid;
    assign o_rsp.now_empty = r_empty;

    // An accepted request always moves on to its execute cycle.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_EXEC))
        else $error("accepted request did not enter its execute cycle");

    // A completed execute cycle offers its result beat on the next cycle.
    a_go_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_go |=> o_rsp.valid)
        else $error("completed operation produced no result beat");

    // A successful push leaves its queue non-empty.
    a_push_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && r_op == OP_PUSH && w_status == STAT_OK) |=> !o_rsp.now_empty)
        else $error("queue reported empty after a successful push");

endmodule

/* rtl/pqe_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
module pqe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/pqe_qtable.sv */
// Head, tail and non-empty flag of every queue, held in flip-flops.
// Depends on pqe_pkg for the update strobe struct.
module pqe_qtable import pqe_pkg::*; #(
    parameter int NUM_SLOTS  = DEF_NUM_SLOTS,
    parameter int NUM_QUEUES = DEF_NUM_QUEUES,
    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1,
    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [QW-1:0] i_rd_idx,
    output logic [SW-1:0] o_head,
    output logic [SW-1:0] o_tail,
    output logic          o_nonempty,
    input  logic [QW-1:0] i_wr_idx,
    input  t_qupd         i_upd,
    input  logic [SW-1:0] i_head,
    input  logic [SW-1:0] i_tail
);
    logic [SW-1:0]         r_head [NUM_QUEUES];
    logic [SW-1:0]         r_tail [NUM_QUEUES];
    logic [NUM_QUEUES-1:0] r_ne;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ne <= '0;
        end else if (i_upd.set_ne) begin
            r_ne[i_wr_idx] <= 1'b1;
        end else if (i_upd.clr_ne) begin
            r_ne[i_wr_idx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd.head_we) begin
            r_head[i_wr_idx] <= i_head;
        end
        if (i_upd.tail_we) begin
            r_tail[i_wr_idx] <= i_tail;
        end
    end

    assign o_head     = r_head[i_rd_idx];
    assign o_tail     = r_tail[i_rd_idx];
    assign o_nonempty = r_ne[i_rd_idx];
endmodule
